// ===== hdl/pdev_pkg.sv =====
package pdev_pkg;

    // Field widths of the channels and the configuration port.
    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int NUM_ORDERS = 4;

    // Falling factorials up to 7*6*5 fit in eight unsigned bits.
    localparam int FACT_W = 8;

    // Width of the rounded product plus a coefficient, before clamping.
    localparam int SUM_W = 49;

    // Width of a coefficient times a falling factorial.
    localparam int SCALED_W = DATA_W + FACT_W + 1;

    // Width of the full Q16.16 by Q16.16 product.
    localparam int PROD_W = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0] word_t;

    // Clamped value and whether the clamp was hit.
    typedef struct packed {
        word_t value;
        logic  clip;
    } sat_t;

    // Product top * (top-1) * ... over cnt factors.
    function automatic int falling_fact(int top, int cnt);
        int f;
        f = 1;
        for (int k = 0; k < cnt; k++)
        begin
            f = f * (top - k);
        end
        return f;
    endfunction

    // Clamp a wide signed value to the signed 32 bit range.
    function automatic sat_t sat_word(logic signed [SUM_W-1:0] v);
        sat_t r;
        r.clip = !((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]));
        if (r.clip)
        begin
            r.value = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/pdev_in_if.sv =====
interface pdev_in_if;
    import pdev_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] point;

    modport source (output valid, output func, output point, input ready);
    modport sink (input valid, input func, input point, output ready);
endinterface

// ===== hdl/pdev_out_if.sv =====
interface pdev_out_if;
    import pdev_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink (input valid, input value, input saturated, output ready);
endinterface

// ===== hdl/polynomial_derivative_evaluator.sv =====
// Throughput: one request per cycle while result.ready holds; each Horner step is a multiply
// stage followed by a round, add and clamp stage, one pair per coefficient below the top one.
// Stages hold their contents under stall and take new requests into any empty slot.
// Reset (rst_n low, asynchronous) clears the coefficients and all stage valid bits.
module polynomial_derivative_evaluator #(
    parameter int COEF_COUNT = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [$clog2(COEF_COUNT)-1:0]         cfg_index,
    input  logic signed [pdev_pkg::DATA_W-1:0]    cfg_data,
    pdev_in_if.sink                               sample,
    pdev_out_if.source                            result
);
    import pdev_pkg::*;

    localparam int IDX_W = $clog2(COEF_COUNT);
    localparam int STEPS = COEF_COUNT - 1;
    localparam int DEPTH = 2 * STEPS + 1;

    // Coefficient registers.
    word_t coef_reg [0:COEF_COUNT-1];

    // Derived coefficients for each derivative order, with their clamp flags.
    word_t dcoef_reg [0:NUM_ORDERS-1][0:COEF_COUNT-1];
    logic  dsat_reg  [0:NUM_ORDERS-1][0:COEF_COUNT-1];

    // Pipeline state: stage 0 holds the request, odd stages a product, even stages an accumulator.
    logic [DEPTH-1:0]        v_reg;
    logic [DEPTH:0]          en;
    word_t                   x_reg    [0:DEPTH-2];
    logic [FUNC_W-1:0]       m_reg    [0:DEPTH-1];
    logic                    flag_reg [1:DEPTH-1];
    logic signed [PROD_W-1:0] prod_reg [0:STEPS-1];
    word_t                   acc_reg  [1:STEPS];

    // Coefficient writes; indexes past the last coefficient are ignored.
    for (genvar i = 0; i < COEF_COUNT; i++)
    begin : g_coef
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                coef_reg[i] <= '0;
            end
            else if (cfg_we && (cfg_index == IDX_W'(i)))
            begin
                coef_reg[i] <= cfg_data;
            end
        end
    end

    // Derived coefficient table: d_j = c_(j+m) * (j+m)!/j!, clamped, zero above the degree.
    for (genvar mo = 0; mo < NUM_ORDERS; mo++)
    begin : g_order
        for (genvar j = 0; j < COEF_COUNT; j++)
        begin : g_term
            if (j + mo < COEF_COUNT)
            begin : g_live
                localparam int FACT = falling_fact(j + mo, mo);
                logic signed [FACT_W:0]     fact_s;
                logic signed [SCALED_W-1:0] scaled;
                sat_t                       dsat;

                always_comb
                begin
                    fact_s = (FACT_W + 1)'(FACT);
                    scaled = coef_reg[j + mo] * fact_s;
                    dsat   = sat_word({{(SUM_W - SCALED_W){scaled[SCALED_W-1]}}, scaled});
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        dcoef_reg[mo][j] <= '0;
                        dsat_reg[mo][j]  <= 1'b0;
                    end
                    else
                    begin
                        dcoef_reg[mo][j] <= dsat.value;
                        dsat_reg[mo][j]  <= dsat.clip;
                    end
                end
            end
            else
            begin : g_zero
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        dcoef_reg[mo][j] <= '0;
                        dsat_reg[mo][j]  <= 1'b0;
                    end
                    else
                    begin
                        dcoef_reg[mo][j] <= '0;
                        dsat_reg[mo][j]  <= 1'b0;
                    end
                end
            end
        end
    end

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        en[DEPTH] = result.ready;
        for (int s = DEPTH - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= sample.valid;
            end
            for (int s = 1; s < DEPTH; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0] <= sample.point;
            m_reg[0] <= sample.func;
        end
    end

    // Horner steps: multiply, then round half up, add the next coefficient and clamp.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam int SA = 2 * i + 1;
        localparam int SB = 2 * i + 2;
        localparam int J  = COEF_COUNT - 2 - i;

        word_t                    mul_a;
        logic                     flag_a;
        logic signed [SUM_W-1:0]  sum;
        sat_t                     acc_sat;
        word_t                    d_sel;
        logic                     d_clip;

        // The first step starts from the top derived coefficient.
        if (i == 0)
        begin : g_first
            always_comb
            begin
                mul_a  = dcoef_reg[m_reg[0]][COEF_COUNT-1];
                flag_a = dsat_reg[m_reg[0]][COEF_COUNT-1];
            end
        end
        else
        begin : g_next
            always_comb
            begin
                mul_a  = acc_reg[i];
                flag_a = flag_reg[SA-1];
            end
        end

        // Multiply stage.
        always_ff @(posedge clk)
        begin
            if (en[SA])
            begin
                prod_reg[i]  <= mul_a * x_reg[SA-1];
                x_reg[SA]    <= x_reg[SA-1];
                m_reg[SA]    <= m_reg[SA-1];
                flag_reg[SA] <= flag_a;
            end
        end

        // Round, accumulate and clamp.
        always_comb
        begin
            d_sel   = dcoef_reg[m_reg[SA]][J];
            d_clip  = dsat_reg[m_reg[SA]][J];
            sum     = {prod_reg[i][PROD_W-1], prod_reg[i][PROD_W-1:16]}
                      + SUM_W'({1'b0, prod_reg[i][15]})
                      + {{(SUM_W - DATA_W){d_sel[DATA_W-1]}}, d_sel};
            acc_sat = sat_word(sum);
        end

        always_ff @(posedge clk)
        begin
            if (en[SB])
            begin
                acc_reg[i+1] <= acc_sat.value;
                m_reg[SB]    <= m_reg[SA];
                flag_reg[SB] <= flag_reg[SA] || d_clip || acc_sat.clip;
            end
        end

        // The point is still needed by every later multiply.
        if (SB < DEPTH - 1)
        begin : g_fwd_x
            always_ff @(posedge clk)
            begin
                if (en[SB])
                begin
                    x_reg[SB] <= x_reg[SA];
                end
            end
        end
    end

    // Result side.
    assign sample.ready     = en[0];
    assign result.valid     = v_reg[DEPTH-1];
    assign result.value     = acc_reg[STEPS];
    assign result.saturated = flag_reg[DEPTH-1];

`ifndef ASSERT_OFF
    // An accepted request lands in the first stage with its point.
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> v_reg[0] && (x_reg[0] == $past(sample.point)))
        else $error("accepted request not captured");

    // A request moving out of the first stage is not dropped.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && en[1] |=> v_reg[1])
        else $error("request lost between first stages");

    // A stalled multiply stage keeps its product.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[1] && !en[1] |=> v_reg[1] && $stable(prod_reg[0]))
        else $error("stalled product changed");

    // The clamp flag is sticky through a step.
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[1] && en[2] && flag_reg[1] |=> flag_reg[2])
        else $error("clamp flag dropped");
`endif

endmodule

// ===== tb/pdev_checker.sv =====
module pdev_checker #(
    parameter int COEF_COUNT = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [$clog2(COEF_COUNT)-1:0]  cfg_index,
    input  pdev_pkg::word_t                cfg_data,
    pdev_in_if                             req_ch,
    pdev_out_if                            rsp_ch,
    output int                             error_count,
    output int                             outstanding
);
    import pdev_pkg::*;

    typedef struct packed {
        word_t value;
        logic  saturated;
    } deriv_result_t;

    // Shadow copy of the coefficient registers, sign extended.
    longint        coef_q [COEF_COUNT];
    deriv_result_t expected_results [$];

    initial
    begin
        error_count = 0;
        outstanding = 0;
    end

    // Clamp to the signed 32 bit range and note any clipping.
    function automatic longint clamp_word(input longint v, inout logic hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Horner evaluation of the selected derivative with per-step rounding and clamping.
    function automatic deriv_result_t eval_derivative(input logic [1:0] order, input word_t x);
        deriv_result_t r;
        longint        acc;
        longint        d;
        longint        scale;
        int            m;
        int            top;
        logic          hit;
        m   = order;
        hit = 1'b0;
        acc = 0;
        if (m < COEF_COUNT)
        begin
            top = COEF_COUNT - 1 - m;
            for (int j = top; j >= 0; j--)
            begin
                scale = 1;
                for (int k = 0; k < m; k++)
                begin
                    scale = scale * (j + m - k);
                end
                d = clamp_word(coef_q[j + m] * scale, hit);
                if (j == top)
                begin
                    acc = d;
                end
                else
                begin
                    acc = clamp_word(((acc * longint'(x) + 64'sd32768) >>> 16) + d, hit);
                end
            end
        end
        r.value     = acc[31:0];
        r.saturated = hit;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Track register writes, predict every request and compare every result.
    always @(posedge clk or negedge rst_n)
    begin
        deriv_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_COUNT; i++)
            begin
                coef_q[i] = 0;
            end
            expected_results.delete();
        end
        else
        begin
            if (cfg_we && cfg_index < COEF_COUNT)
            begin
                coef_q[cfg_index] = longint'(cfg_data);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no request pending", rsp_ch.value, 32'h0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.value !== want.value)
                    begin
                        report_mismatch("value", rsp_ch.value, want.value);
                    end
                    if (rsp_ch.saturated !== want.saturated)
                    begin
                        report_mismatch("saturated", {31'b0, rsp_ch.saturated},
                                        {31'b0, want.saturated});
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                // Append the prediction at the tail of the queue.
                expected_results.insert(expected_results.size(),
                                        eval_derivative(req_ch.func, req_ch.point));
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import pdev_pkg::*;

    localparam int    COEF_COUNT   = 6;
    localparam int    IDX_W        = $clog2(COEF_COUNT);
    localparam int    CYCLE_LIMIT  = 600000;
    localparam int    DRAIN_CYCLES = 4 * COEF_COUNT;
    localparam int    PHASES       = 12;
    localparam int    PHASE_ITEMS  = 140;
    localparam word_t WORD_MAX     = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN     = 32'sh8000_0000;
    localparam word_t ONE          = 32'sh0001_0000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    word_t            cfg_data;
    int               error_count;
    int               outstanding;
    int               cycle_count;
    bit               calm;

    pdev_in_if  sample_if ();
    pdev_out_if result_if ();

    polynomial_derivative_evaluator #(
        .COEF_COUNT (COEF_COUNT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_if),
        .result    (result_if)
    );

    pdev_checker #(
        .COEF_COUNT (COEF_COUNT)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_ch      (sample_if),
        .rsp_ch      (result_if),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Watchdog on total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Idle cycles before the next request or result; none during calm stretches.
    function automatic int draw_wait();
        if (calm)
        begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic word_t signed_upto(input int unsigned span);
        word_t w;
        w = $urandom_range(0, span);
        if ($urandom_range(0, 1) == 1)
        begin
            w = -w;
        end
        return w;
    endfunction

    function automatic word_t pick_extreme();
        case ($urandom_range(0, 6))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return ONE;
            3: return -ONE;
            4: return 32'sd1;
            5: return -32'sd1;
            default: return 32'sd0;
        endcase
    endfunction

    // Evaluation points: mostly small magnitudes so that results stay in range.
    function automatic word_t rand_point();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: return signed_upto(32'h0004_0000);
            6, 7:    return signed_upto(ONE);
            8:       return pick_extreme();
            default: return signed_upto(32'h0100_0000);
        endcase
    endfunction

    function automatic word_t rand_coef(input int style);
        case (style)
            0: return $urandom;
            1: return signed_upto(32'h0004_0000);
            2: return signed_upto(ONE);
            default:
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    return pick_extreme();
                end
                return signed_upto(32'h0010_0000);
            end
        endcase
    endfunction

    task automatic write_reg(input int idx, input word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx[IDX_W-1:0];
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Wait for the pipeline to empty, then load all coefficients and poke the unused indexes.
    task automatic load_coefs(input word_t c [COEF_COUNT]);
        sample_if.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        for (int i = 0; i < COEF_COUNT; i++)
        begin
            write_reg(i, c[i]);
        end
        for (int i = COEF_COUNT; i < (1 << IDX_W); i++)
        begin
            write_reg(i, $urandom);
        end
        cfg_we <= 1'b0;
    endtask

    // Present one request after a random gap and hold it until accepted.
    task automatic send_req(input logic [1:0] f, input word_t x);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.func  <= f;
        sample_if.point <= x;
        do
        begin
            @(posedge clk);
        end
        while (!sample_if.ready);
        @(negedge clk);
    endtask

    // Result side: random stall before taking each result.
    initial
    begin
        int n;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            n = draw_wait();
            if (n > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!result_if.valid);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        word_t coefs [COEF_COUNT];
        int    degree;
        int    style;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        sample_if.valid = 1'b0;
        sample_if.func  = '0;
        sample_if.point = '0;
        calm            = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Coefficients straight out of reset give zero everywhere.
        send_req(2'd0, WORD_MAX);

        // A moderate polynomial at the unit points and the origin, every order.
        coefs = '{ONE, -2 * ONE, 32'sh8000, 3 * ONE, -ONE, 32'sh4000};
        load_coefs(coefs);
        for (int f = 0; f < NUM_ORDERS; f++)
        begin
            send_req(f[1:0], 32'sd0);
            send_req(f[1:0], ONE);
            send_req(f[1:0], -ONE);
        end

        // Largest coefficients at the largest point clip at every order.
        coefs = '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
        load_coefs(coefs);
        for (int f = 0; f < NUM_ORDERS; f++)
        begin
            send_req(f[1:0], WORD_MAX);
        end

        // Most negative coefficients at the most negative point.
        coefs = '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};
        load_coefs(coefs);
        send_req(2'd0, WORD_MIN);
        send_req(2'd3, WORD_MIN);

        // A clipped derived coefficient multiplied away by x = 0 still leaves the flag set.
        coefs = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, WORD_MAX};
        load_coefs(coefs);
        send_req(2'd0, 32'sd0);
        send_req(2'd1, 32'sd0);
        send_req(2'd3, 32'sd0);

        // Random phases: each with its own degree, coefficient style and idling pattern.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            calm   = ($urandom_range(0, 3) == 0);
            degree = $urandom_range(0, COEF_COUNT - 1);
            style  = $urandom_range(0, 3);
            for (int i = 0; i < COEF_COUNT; i++)
            begin
                coefs[i] = (i > degree) ? 32'sd0 : rand_coef(style);
            end
            load_coefs(coefs);
            repeat (PHASE_ITEMS) send_req(2'($urandom_range(0, 3)), rand_point());
        end

        // Drain and report.
        sample_if.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pdev_pkg.sv
hdl/pdev_in_if.sv
hdl/pdev_out_if.sv
hdl/polynomial_derivative_evaluator.sv
tb/pdev_checker.sv
tb/testbench.sv
